FILE: design/acoe_pkg.sv
`timescale 1ns / 1ps

package acoe_pkg;

  // Request opcode
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } acoe_cmd_t;

  // Control that the top level hands to every entry cell
  typedef struct packed {
    logic ins;     // an insert beat is accepted this cycle
    logic tok_in;  // write token offered by the upper neighbor
  } acoe_cell_ctl_t;

endpackage

FILE: design/acoe_if.sv
`timescale 1ns / 1ps

interface acoe_req_if #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
);
  import acoe_pkg::*;

  logic                  valid;
  logic                  ready;
  acoe_cmd_t             cmd;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value_in;

  modport source (output valid, cmd, key, value_in, input ready);
  modport sink   (input valid, cmd, key, value_in, output ready);
endinterface

interface acoe_rsp_if #(
  parameter int VALUE_BITS = 32,
  parameter int SLOT_BITS  = 4
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] value_out;
  logic [SLOT_BITS-1:0]  slot;

  modport source (output valid, hit, value_out, slot, input ready);
  modport sink   (input valid, hit, value_out, slot, output ready);
endinterface

FILE: design/acoe_cell.sv
`timescale 1ns / 1ps

module acoe_cell #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32,
  parameter bit TOKEN_INIT = 1'b0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  acoe_pkg::acoe_cell_ctl_t ctl,
  input  logic [KEY_BITS-1:0]      key,
  input  logic [VALUE_BITS-1:0]    value_in,
  output logic                     match,
  output logic [VALUE_BITS-1:0]    value_out,
  output logic                     tok
);

  logic                  valid_r;
  logic                  tok_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= TOKEN_INIT;
    end else if (ctl.ins) begin
      // pass the token one cell down on every insert
      tok_r <= ctl.tok_in;
      if (tok_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && tok_r) begin
      key_r   <= key;
      value_r <= value_in;
    end
  end

  assign match     = valid_r && (key_r == key);
  assign value_out = value_r;
  assign tok       = tok_r;

endmodule

FILE: design/assoc_cache_insert_order_evict.sv
`timescale 1ns / 1ps

// Fully associative key/value cache of ENTRIES entries, built as a row of
// entry cells. A lookup compares its key against every cell in parallel and
// returns the lowest-index valid match (hit, value, slot); a miss returns all
// zeros. An insert writes key and value without a duplicate check into the
// cell holding the write token and reports that slot. The token starts at the
// top cell and steps one cell down (wrapping to the top) on every insert, so
// empty slots fill from the highest index down and, once full, entries are
// replaced in insertion order; lookups never move it. One request is taken
// per cycle while the output is empty or out_if.ready is high. The compare
// across the whole cell row and the priority pick are combinational, and the
// result sits in the output register in the cycle after the request beat.

module assoc_cache_insert_order_evict #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  acoe_req_if.sink   in_if,
  acoe_rsp_if.source out_if
);
  import acoe_pkg::*;

  localparam int SLOT_BITS = $clog2(ENTRIES);

  logic                  out_valid_r;
  logic                  hit_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [SLOT_BITS-1:0]  slot_r;

  logic                  accept;
  logic                  is_ins;
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    tok_vec;
  logic [ENTRIES-1:0]    first_vec;
  logic [ENTRIES-1:0]    sel_vec;
  logic [VALUE_BITS-1:0] cell_val [ENTRIES];
  acoe_cell_ctl_t        cell_ctl [ENTRIES];

  logic                  hit_nxt;
  logic [VALUE_BITS-1:0] value_nxt;
  logic [SLOT_BITS-1:0]  slot_nxt;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_ins      = (in_if.cmd == CMD_INSERT);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    // take the token from the upper neighbor; the top cell closes the ring
    assign cell_ctl[g].ins    = accept && is_ins;
    assign cell_ctl[g].tok_in = tok_vec[(g + 1) % ENTRIES];

    acoe_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .TOKEN_INIT (g == ENTRIES - 1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl[g]),
      .key       (in_if.key),
      .value_in  (in_if.value_in),
      .match     (match_vec[g]),
      .value_out (cell_val[g]),
      .tok       (tok_vec[g])
    );
  end

  // isolate the lowest-index match
  assign first_vec = is_ins ? '0 : (match_vec & (~match_vec + ENTRIES'(1)));
  assign sel_vec   = is_ins ? tok_vec : first_vec;

  always_comb begin
    hit_nxt   = |first_vec;
    value_nxt = '0;
    slot_nxt  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_vec[i]) begin
        value_nxt = value_nxt | cell_val[i];
      end
      if (sel_vec[i]) begin
        slot_nxt = slot_nxt | SLOT_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r   <= hit_nxt;
      value_r <= value_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.hit       = hit_r;
  assign out_if.value_out = value_r;
  assign out_if.slot      = slot_r;

endmodule
